// ===== design/msft_pkg.sv =====
package msft_pkg;

	// built server count and derived widths
	localparam int MAX_SERVERS = 16;
	localparam int SRV_W       = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;

	// fixed field widths
	localparam int TIME_W = 48;
	localparam int DUR_W  = 32;
	localparam int CNT_W  = 5;

	// configuration port
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	// register indexes
	localparam logic REG_SERVER_COUNT = 1'b0;

	localparam logic [CNT_W-1:0] SERVER_COUNT_RST = CNT_W'(1);

	// controller to datapath
	typedef struct packed {
		logic load_in;  // capture input beat, restart scan
		logic scan_en;  // compare one stored free time
		logic calc;     // start and saturated finish
		logic commit;   // write back, load output register
	} msft_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_last; // current scan index is the last server in use
	} msft_sts_t;

endpackage

// ===== design/multi_server_finish_time.sv =====
// Multi-server FCFS finish time.
// Input channel (in_valid/in_ready) takes one request per beat: arrival_time
// and service_duration. Output channel (out_valid/out_ready) returns one
// finish_time per request, in request order.
// Each request goes to the server in use that is free earliest (lowest index
// on ties); service starts at the later of arrival and that free time, and
// finish = start + duration saturates at 2^48-1 and becomes the server's
// new free time.
// Steps: accept, a scan of the stored free times over the servers in use, add
// and saturate, write back. A new request is taken only after write back.
// A request is accepted while a previous result still waits in the output
// register; if the receiver stalls, write back holds until that result is
// taken, and in_ready stays low meanwhile.
// server_count sits at APB byte address 0 (reset 1); 0 acts as 1, counts
// above the built server count are clamped. Write it only while idle.
// Reset clears all server free times to zero and empties the output register.
module multi_server_finish_time (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [msft_pkg::ADDR_W-1:0]      paddr,
	input  logic [msft_pkg::DATA_W-1:0]      pwdata,
	output logic [msft_pkg::DATA_W-1:0]      prdata,
	output logic                             pready,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [msft_pkg::TIME_W-1:0]      arrival_time,
	input  logic [msft_pkg::DUR_W-1:0]       service_duration,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [msft_pkg::TIME_W-1:0]      finish_time
);
	import msft_pkg::*;

	logic [CNT_W-1:0] server_count_q;
	logic             reg_idx;
	msft_cmd_t        cmd;
	msft_sts_t        sts;

	assign pready  = 1'b1;
	assign reg_idx = paddr[2];

	// configuration register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			server_count_q <= SERVER_COUNT_RST;
		end else if (psel && penable && pwrite && pready) begin
			unique case (reg_idx)
				REG_SERVER_COUNT: server_count_q <= pwdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		unique case (reg_idx)
			REG_SERVER_COUNT: prdata = {{(DATA_W-CNT_W){1'b0}}, server_count_q};
			default:          prdata = '0;
		endcase
	end

	msft_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	msft_datapath u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.server_count     (server_count_q),
		.arrival_time     (arrival_time),
		.service_duration (service_duration),
		.finish_time      (finish_time)
	);

endmodule

// ===== design/msft_datapath.sv =====
module msft_datapath (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  msft_pkg::msft_cmd_t                   cmd,
	output msft_pkg::msft_sts_t                   sts,
	input  logic [msft_pkg::CNT_W-1:0]            server_count,
	input  logic [msft_pkg::TIME_W-1:0]           arrival_time,
	input  logic [msft_pkg::DUR_W-1:0]            service_duration,
	output logic [msft_pkg::TIME_W-1:0]           finish_time
);
	import msft_pkg::*;

	logic [TIME_W-1:0] free_q [MAX_SERVERS];
	logic [TIME_W-1:0] arrival_q;
	logic [DUR_W-1:0]  duration_q;
	logic [SRV_W-1:0]  scan_idx_q;
	logic [SRV_W-1:0]  best_idx_q;
	logic [TIME_W-1:0] best_val_q;
	logic [TIME_W-1:0] finish_q;
	logic [TIME_W-1:0] finish_time_q;

	logic [SRV_W-1:0]  last_idx;
	logic [CNT_W-1:0]  cnt_m1;
	logic [TIME_W-1:0] rd_val;
	logic [TIME_W-1:0] start_val;
	logic [TIME_W:0]   sum_val;

	// last server in use: zero counts as one, clamp at the built count
	always_comb begin
		cnt_m1 = server_count - CNT_W'(1);
		if (server_count == '0) begin
			last_idx = '0;
		end else if (int'(server_count) > MAX_SERVERS) begin
			last_idx = SRV_W'(MAX_SERVERS - 1);
		end else begin
			last_idx = SRV_W'(cnt_m1);
		end
	end

	assign sts.scan_last = (scan_idx_q == last_idx);
	assign rd_val        = free_q[scan_idx_q];

	// later of arrival and free time, plus duration, saturated
	always_comb begin
		start_val = (arrival_q > best_val_q) ? arrival_q : best_val_q;
		sum_val   = {1'b0, start_val} + {{(TIME_W+1-DUR_W){1'b0}}, duration_q};
	end

	// input capture, earliest-free scan, finish calc
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			arrival_q  <= arrival_time;
			duration_q <= service_duration;
			scan_idx_q <= '0;
		end
		if (cmd.scan_en) begin
			// strict less-than keeps the lowest index on ties
			if (scan_idx_q == '0 || rd_val < best_val_q) begin
				best_val_q <= rd_val;
				best_idx_q <= scan_idx_q;
			end
			if (!sts.scan_last) begin
				scan_idx_q <= scan_idx_q + SRV_W'(1);
			end
		end
		if (cmd.calc) begin
			finish_q <= sum_val[TIME_W] ? {TIME_W{1'b1}} : sum_val[TIME_W-1:0];
		end
		if (cmd.commit) begin
			finish_time_q <= finish_q;
		end
	end

	// server free times, all zero after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_SERVERS; i++) begin
				free_q[i] <= '0;
			end
		end else if (cmd.commit) begin
			free_q[best_idx_q] <= finish_q;
		end
	end

	assign finish_time = finish_time_q;

endmodule

// ===== design/msft_ctrl.sv =====
module msft_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  msft_pkg::msft_sts_t sts,
	output msft_pkg::msft_cmd_t cmd
);
	import msft_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_CALC,
		ST_COMMIT
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	// commands decoded from state
	always_comb begin
		cmd.load_in = (state_q == ST_IDLE) && in_valid;
		cmd.scan_en = (state_q == ST_SCAN);
		cmd.calc    = (state_q == ST_CALC);
		cmd.commit  = (state_q == ST_COMMIT) && out_free;
	end

	// sequencer and output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			// a new result replaces the one taken in the same cycle
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (sts.scan_last) begin
						state_q <= ST_CALC;
					end
				end
				ST_CALC: begin
					state_q <= ST_COMMIT;
				end
				ST_COMMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// a result never overwrites one still waiting
	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!out_valid_q || out_ready))
		else $error("commit while output register is occupied");

	a_commit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid)
		else $error("output not valid after commit");

	a_accept_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == ST_SCAN))
		else $error("accepted beat did not start a scan");

	a_scan_end: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.scan_en && sts.scan_last) |=> (state_q == ST_CALC))
		else $error("scan did not end on last server");

endmodule

// ===== bench/multi_server_finish_time_tb.sv =====
module multi_server_finish_time_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import msft_pkg::*;

	localparam logic [ADDR_W-1:0] ADDR_COUNT  = ADDR_W'({REG_SERVER_COUNT, 2'b00});
	// one register index past the list: writes there are dropped
	localparam logic [ADDR_W-1:0] ADDR_UNUSED = ADDR_W'(4);

	localparam logic [TIME_W-1:0] TIME_MAX = '1;

	localparam int DIR_ROWS      = 25;
	localparam int RANDOM_PHASES = 12;
	localparam int PHASE_ITEMS   = 153;
	localparam int STUCK_LIMIT   = 2000;
	localparam int TAIL_CYCLES   = 40;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t          kind;
		logic [ADDR_W-1:0]  addr;
		logic [DATA_W-1:0]  data;
		logic [TIME_W-1:0]  arr;
		logic [DUR_W-1:0]   dur;
		logic               known;
		logic [TIME_W-1:0]  want;
	} stim_row_t;

	typedef enum int {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_COMB} rx_mode_t;

	logic                clk              = 1'b0;
	logic                arst_n           = 1'b0;
	logic                psel             = 1'b0;
	logic                penable          = 1'b0;
	logic                pwrite           = 1'b0;
	logic [ADDR_W-1:0]   paddr            = '0;
	logic [DATA_W-1:0]   pwdata           = '0;
	logic [DATA_W-1:0]   prdata;
	logic                pready;
	logic                in_valid         = 1'b0;
	logic                in_ready;
	logic [TIME_W-1:0]   arrival_time     = '0;
	logic [DUR_W-1:0]    service_duration = '0;
	logic                out_valid;
	logic                out_ready        = 1'b0;
	logic [TIME_W-1:0]   finish_time;

	// predictor state: configured count and per-server free time
	logic [CNT_W-1:0]    count_cfg = SERVER_COUNT_RST;
	logic [TIME_W-1:0]   free_at [MAX_SERVERS];

	logic [TIME_W-1:0]   finish_q [$];
	stim_row_t           dir_tab [DIR_ROWS];

	int                  error_count  = 0;
	int                  stuck_cycles = 0;
	int                  burst_left   = 0;
	rx_mode_t            rx_mode      = RX_ALWAYS;
	int                  rx_hold      = 0;

	multi_server_finish_time DUT (
		.clk              (clk),
		.arst_n           (arst_n),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.prdata           (prdata),
		.pready           (pready),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.arrival_time     (arrival_time),
		.service_duration (service_duration),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.finish_time      (finish_time)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		foreach (free_at[s]) free_at[s] = '0;
	end

	// earliest-free server, lowest index on ties; finish saturates
	function automatic logic [TIME_W-1:0] predict_finish(input logic [TIME_W-1:0] arr,
		input logic [DUR_W-1:0] dur);
		int               in_use;
		int               pick;
		int               s;
		logic [TIME_W-1:0] begin_at;
		logic [TIME_W:0]   total;
		logic [TIME_W-1:0] done_at;
		if (count_cfg == 0)
			in_use = 1;
		else if (count_cfg > MAX_SERVERS)
			in_use = MAX_SERVERS;
		else
			in_use = int'(count_cfg);
		pick = 0;
		for (s = 1; s < in_use; s++)
			if (free_at[s] < free_at[pick]) pick = s;
		begin_at = (arr > free_at[pick]) ? arr : free_at[pick];
		total = {1'b0, begin_at} + (TIME_W+1)'(dur);
		done_at = total[TIME_W] ? TIME_MAX : total[TIME_W-1:0];
		free_at[pick] = done_at;
		return done_at;
	endfunction

	// sender pacing: bursts of beats with random gaps between them
	task automatic pace_sender();
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
	endtask

	task automatic send_request(input logic [TIME_W-1:0] arr, input logic [DUR_W-1:0] dur,
		input logic known, input logic [TIME_W-1:0] want);
		logic [TIME_W-1:0] predicted;
		in_valid         <= 1'b1;
		arrival_time     <= arr;
		service_duration <= dur;
		do @(posedge clk); while (!in_ready);
		predicted = predict_finish(arr, dur);
		finish_q.push_back(known ? want : predicted);
	endtask

	// stop sending and wait for every outstanding finish beat
	task automatic drain_requests();
		in_valid <= 1'b0;
		while (finish_q.size() != 0) @(posedge clk);
	endtask

	task automatic read_back_count();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= ADDR_COUNT;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== DATA_W'(count_cfg)) begin
			$error("server_count: expected %0h, got %0h", DATA_W'(count_cfg), prdata);
			error_count++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_register(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (addr == ADDR_COUNT) count_cfg = data[CNT_W-1:0];
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		if (addr == ADDR_COUNT) read_back_count();
	endtask

	// receiver stall pattern, changes character when its random hold count runs out
	always @(posedge clk) begin
		if (rx_hold == 0) begin
			rx_mode <= rx_mode_t'($urandom_range(0, 3));
			rx_hold <= $urandom_range(32, 400);
		end else begin
			rx_hold <= rx_hold - 1;
		end
		case (rx_mode)
			RX_ALWAYS: out_ready <= 1'b1;
			RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
			RX_SPARSE: out_ready <= ($urandom_range(0, 7) == 0);
			default:   out_ready <= (rx_hold[2:0] < 3);
		endcase
	end

	// finish beat check and stall watchdog
	always @(posedge clk) begin
		logic [TIME_W-1:0] want;
		if (arst_n && out_valid && out_ready) begin
			if (finish_q.size() == 0) begin
				$error("finish_time: expected none, got %0h", finish_time);
				error_count++;
			end else begin
				want = finish_q.pop_front();
				if (finish_time !== want) begin
					$error("finish_time: expected %0h, got %0h", want, finish_time);
					error_count++;
				end
			end
		end
		if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
			stuck_cycles = 0;
		else
			stuck_cycles++;
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		logic [TIME_W-1:0] arrival_clock;
		logic [TIME_W-1:0] arr;
		logic [DUR_W-1:0]  dur;
		logic [DATA_W-1:0] word;
		logic [CNT_W-1:0]  cnt;
		int                roll;

		// directed rows; typed results only where obvious
		dir_tab = '{
			'{ROW_ITEM, ADDR_COUNT,  32'h0, 48'h0000_0000_0000, 32'h0000_0000, 1'b1,
				48'h0000_0000_0000},
			'{ROW_ITEM, ADDR_COUNT,  32'h0, 48'h0000_0000_0000, 32'h0000_0007, 1'b1,
				48'h0000_0000_0007},
			// server still busy
			'{ROW_ITEM, ADDR_COUNT,  32'h0, 48'h0000_0000_0002, 32'h0000_0003, 1'b1,
				48'h0000_0000_000A},
			// arrival earlier than the previous one
			'{ROW_ITEM, ADDR_COUNT,  32'h0, 48'h0000_0000_0001, 32'h0000_0000, 1'b1,
				48'h0000_0000_000A},
			'{ROW_ITEM, ADDR_COUNT,  32'h0, 48'h0000_0000_000A, 32'hFFFF_FFFF, 1'b1,
				48'h0001_0000_0009},
			// zero servers acts as one
			'{ROW_CFG,  ADDR_COUNT,  32'h0000_0000, 48'h0, 32'h0, 1'b0, 48'h0},
			'{ROW_ITEM, ADDR_COUNT,  32'h0, 48'h0001_0000_0010, 32'h0000_0001, 1'b1,
				48'h0001_0000_0011},
			'{ROW_CFG,  ADDR_COUNT,  32'h0000_0004, 48'h0, 32'h0, 1'b0, 48'h0},
			'{ROW_ITEM, ADDR_COUNT,  32'h0, 48'h0001_0000_0020, 32'h0000_0005, 1'b1,
				48'h0001_0000_0025},
			'{ROW_ITEM, ADDR_COUNT,  32'h0, 48'h0001_0000_0020, 32'h0000_0005, 1'b1,
				48'h0001_0000_0025},
			'{ROW_ITEM, ADDR_COUNT,  32'h0, 48'h0001_0000_0020, 32'h0000_0005, 1'b1,
				48'h0001_0000_0025},
			'{ROW_ITEM, ADDR_COUNT,  32'h0, 48'h0001_0000_0020, 32'h0000_0005, 1'b1,
				48'h0001_0000_0025},
			// four-way tie: server 0 must take it
			'{ROW_ITEM, ADDR_COUNT,  32'h0, 48'h0001_0000_0020, 32'h0000_0001, 1'b1,
				48'h0001_0000_0026},
			'{ROW_CFG,  ADDR_COUNT,  32'h0000_0001, 48'h0, 32'h0, 1'b0, 48'h0},
			// write past the register list is dropped
			'{ROW_CFG,  ADDR_UNUSED, 32'hFFFF_FFFF, 48'h0, 32'h0, 1'b0, 48'h0},
			'{ROW_ITEM, ADDR_COUNT,  32'h0, 48'h0001_0000_0020, 32'h0000_0000, 1'b1,
				48'h0001_0000_0026},
			// 31 clamps to the built count
			'{ROW_CFG,  ADDR_COUNT,  32'hFFFF_FFFF, 48'h0, 32'h0, 1'b0, 48'h0},
			'{ROW_ITEM, ADDR_COUNT,  32'h0, 48'h0001_0000_0030, 32'h0000_0002, 1'b1,
				48'h0001_0000_0032},
			// upper bits dropped: count field is zero
			'{ROW_CFG,  ADDR_COUNT,  32'h0000_0020, 48'h0, 32'h0, 1'b0, 48'h0},
			// back to one server, parked free times come back
			'{ROW_ITEM, ADDR_COUNT,  32'h0, 48'h0000_0000_0000, 32'h0000_0000, 1'b1,
				48'h0001_0000_0026},
			'{ROW_CFG,  ADDR_COUNT,  32'h0000_0011, 48'h0, 32'h0, 1'b0, 48'h0},
			// saturation: both fields at max, exact max, max plus one
			'{ROW_ITEM, ADDR_COUNT,  32'h0, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
				48'hFFFF_FFFF_FFFF},
			'{ROW_ITEM, ADDR_COUNT,  32'h0, 48'hFFFF_FFFF_0000, 32'h0000_FFFF, 1'b1,
				48'hFFFF_FFFF_FFFF},
			'{ROW_ITEM, ADDR_COUNT,  32'h0, 48'hFFFF_FFFF_0000, 32'h0001_0000, 1'b1,
				48'hFFFF_FFFF_FFFF},
			'{ROW_ITEM, ADDR_COUNT,  32'h0, 48'h0001_0000_0040, 32'h0000_0003, 1'b0,
				48'h0}
		};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		read_back_count();

		// directed part
		foreach (dir_tab[r]) begin
			if (dir_tab[r].kind == ROW_CFG) begin
				drain_requests();
				write_register(dir_tab[r].addr, dir_tab[r].data);
			end else begin
				pace_sender();
				send_request(dir_tab[r].arr, dir_tab[r].dur, dir_tab[r].known, dir_tab[r].want);
			end
		end

		// random part: mostly ordered arrivals, some late ones and long jumps
		arrival_clock = 48'h0001_0000_0100;
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0:       cnt = 5'd16;
				1:       cnt = 5'd1;
				2:       cnt = 5'd31;
				3:       cnt = 5'd0;
				4:       cnt = 5'd3;
				5:       cnt = 5'd17;
				6:       cnt = 5'd8;
				7:       cnt = 5'd2;
				default: cnt = CNT_W'($urandom_range(0, 31));
			endcase
			drain_requests();
			if ($urandom_range(0, 1) == 1) write_register(ADDR_UNUSED, $urandom());
			word = $urandom();
			word[CNT_W-1:0] = cnt;
			write_register(ADDR_COUNT, word);

			for (int n = 0; n < PHASE_ITEMS; n++) begin
				roll = $urandom_range(0, 99);
				if (roll < 85) begin
					if ($urandom_range(0, 9) < 7)
						arrival_clock += TIME_W'($urandom_range(0, 20));
					else
						arrival_clock += TIME_W'($urandom_range(0, 2000));
					arr = arrival_clock;
				end else if (roll < 95) begin
					arr = arrival_clock - TIME_W'($urandom_range(0, 1000));
				end else begin
					arrival_clock += TIME_W'($urandom());
					arr = arrival_clock;
				end
				roll = $urandom_range(0, 9);
				if (roll < 6)
					dur = $urandom_range(0, 60);
				else if (roll < 9)
					dur = $urandom_range(0, 5000);
				else
					dur = $urandom();
				pace_sender();
				send_request(arr, dur, 1'b0, '0);
			end
		end

		drain_requests();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
